@@ rtl/day_number_to_date_core_assert.svh @@
// Assertion macros shared by the day number to date modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DAY_NUMBER_TO_DATE_CORE_ASSERT_SVH
`define DAY_NUMBER_TO_DATE_CORE_ASSERT_SVH

// Same-cycle implication.
`define D2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("day_number_to_date_core: same-cycle check failed");

// Next-cycle implication.
`define D2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("day_number_to_date_core: next-cycle check failed");

// Invariant that holds on every clock edge out of reset.
`define D2D_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("day_number_to_date_core: invariant failed");

`endif

@@ rtl/d2d_pkg.sv @@
`default_nettype none

package d2d_pkg;

  localparam int unsigned DayW   = 22;  // input day number
  localparam int unsigned YearW  = 14;  // calendar year
  localparam int unsigned MonW   = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned RemW   = 11;  // remainder of a 1461-day block
  localparam int unsigned QuotW  = 12;  // number of whole blocks
  localparam int unsigned YLenW  = 9;
  localparam int unsigned MLenW  = 5;
  localparam int unsigned ProdW  = 2 * DayW;
  localparam int unsigned RecipShift = 32;

  localparam logic [RemW:0]   BlockDays   = 12'd1461;
  // Rounded-up 2^32 / 1461; the top product bits give the exact block count
  // for every 22-bit day number.
  localparam logic [DayW-1:0]  BlockRecip  = 22'd2939745;
  localparam logic [YLenW-1:0] YearDays    = 9'd365;
  localparam logic [YLenW-1:0] LeapDays    = 9'd366;
  localparam logic [MonW-1:0]  MonthFeb    = 4'd1;
  localparam logic [MonW-1:0]  MonthDec    = 4'd11;

  typedef struct packed {
    logic load;
    logic year_step;
    logic div_step;
    logic div_done;
    logic month_step;
    logic capture;
  } d2d_cmd_t;

  typedef struct packed {
    logic inv;
    logic aligned;
    logic d_ge_ylen;
    logic month_last;
    logic out_free;
  } d2d_stat_t;

  // Days in a month, index 0 = January, with the leap day added to February.
  function automatic logic [MLenW-1:0] month_days(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [MLenW-1:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/day_number_to_date_core.sv @@
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[21:0] day_number
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: day, month, year, packed date;
//                                             tuser: invalid
//
// One item is converted at a time. A reciprocal multiply splits off whole 1461-day
// blocks in the S_DIV and S_QADD states; years and months are then walked one step
// per cycle. m_axis_tvalid rises on the capture of a result, and s_axis_tready rises
// with it, so the next item is accepted while the result waits for m_axis_tready.
// A result still held stalls the next capture; reset idles the controller, drops tvalid.
`default_nettype none

module day_number_to_date_core #(
  parameter int unsigned EPOCH_YEAR = 1600
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [21:0] day_number, [23:22] zero
  // Result item.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [4:0] day_of_month, [8:5] month,
                                           // [22:9] year, [54:23] packed_date,
                                           // [55] zero
  output logic             m_axis_tuser    // [0] invalid
);

  d2d_pkg::d2d_cmd_t  cmd;
  d2d_pkg::d2d_stat_t stat;

  logic [d2d_pkg::DomW-1:0]  out_day;
  logic [d2d_pkg::MonW-1:0]  out_mon;
  logic [d2d_pkg::YearW-1:0] out_year;
  logic                      out_inv;
  logic [31:0]               packed_date;

  // The controller sequences the align, divide, year and month phases.
  d2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the remaining days, the year, the month, the block
  // count and the output register.
  d2d_dp #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .day_number_i (s_axis_tdata[d2d_pkg::DayW-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_day_o    (out_day),
    .out_mon_o    (out_mon),
    .out_year_o   (out_year),
    .out_inv_o    (out_inv)
  );

  // Packed word: day in bits 7..0, month in 15..8, year in 31..16.
  assign packed_date = {2'b00, out_year, 4'b0000, out_mon, 3'b000, out_day};

  assign m_axis_tdata = {1'b0, packed_date, out_year, out_mon, out_day};
  assign m_axis_tuser = out_inv;

endmodule

`default_nettype wire

@@ rtl/d2d_ctrl.sv @@
`default_nettype none
`include "day_number_to_date_core_assert.svh"

module d2d_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire d2d_pkg::d2d_stat_t stat_i,
  output d2d_pkg::d2d_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_QADD  = 3'd3;
  localparam logic [2:0] S_YEARS = 3'd4;
  localparam logic [2:0] S_MONTH = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ALIGN;
        end
      end
      S_ALIGN: begin
        // Step single years until the year is a multiple of four or the days left fit in it.
        if (stat_i.inv) begin
          state_d = S_FIN;
        end else if (!stat_i.aligned && stat_i.d_ge_ylen) begin
          cmd_o.year_step = 1'b1;
        end else if (stat_i.aligned) begin
          state_d = S_DIV;
        end else begin
          state_d = S_YEARS;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_QADD;
      end
      S_QADD: begin
        cmd_o.div_done = 1'b1;
        state_d        = S_YEARS;
      end
      S_YEARS: begin
        if (stat_i.d_ge_ylen) begin
          cmd_o.year_step = 1'b1;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (stat_i.month_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The divider only runs on a year that is a multiple of four.
  `D2D_ASSERT_IMP(a_div_aligned, state_q == S_DIV, stat_i.aligned)
  // At most one datapath operation is issued per cycle.
  `D2D_ASSERT_ALW(a_cmd_onehot, $onehot0({cmd_o.load, cmd_o.year_step, cmd_o.div_step,
                                          cmd_o.div_done, cmd_o.month_step, cmd_o.capture}))

endmodule

`default_nettype wire

@@ rtl/d2d_dp.sv @@
`default_nettype none
`include "day_number_to_date_core_assert.svh"

module d2d_dp #(
  parameter int unsigned EPOCH_YEAR = 1600
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [d2d_pkg::DayW-1:0]    day_number_i,
  input  wire d2d_pkg::d2d_cmd_t           cmd_i,
  output d2d_pkg::d2d_stat_t               stat_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [d2d_pkg::DomW-1:0]         out_day_o,
  output logic [d2d_pkg::MonW-1:0]         out_mon_o,
  output logic [d2d_pkg::YearW-1:0]        out_year_o,
  output logic                             out_inv_o
);

  logic [d2d_pkg::DayW-1:0]  d_q, d_d;
  logic [d2d_pkg::YearW-1:0] y_q, y_d;
  logic [d2d_pkg::MonW-1:0]  m_q, m_d;
  logic [d2d_pkg::QuotW-1:0] q_q, q_d;
  logic                      inv_q, inv_d;

  logic                      valid_q;
  logic [d2d_pkg::DomW-1:0]  o_day_q;
  logic [d2d_pkg::MonW-1:0]  o_mon_q;
  logic [d2d_pkg::YearW-1:0] o_year_q;
  logic                      o_inv_q;

  logic                       leap;
  logic [d2d_pkg::YLenW-1:0]  ylen;
  logic [d2d_pkg::MLenW-1:0]  mlen;
  logic [d2d_pkg::ProdW-1:0]  prod;
  logic [d2d_pkg::DayW-1:0]   blk_days;

  assign leap     = (y_q[1:0] == 2'b00);
  assign ylen     = leap ? d2d_pkg::LeapDays : d2d_pkg::YearDays;
  assign mlen     = d2d_pkg::month_days(m_q, leap);
  // Whole 1461-day blocks: the day count times a scaled reciprocal.
  assign prod     = d2d_pkg::ProdW'(d_q) * d2d_pkg::ProdW'(d2d_pkg::BlockRecip);
  assign blk_days = d2d_pkg::DayW'(q_q) * d2d_pkg::DayW'(d2d_pkg::BlockDays);

  assign stat_o.inv        = inv_q;
  assign stat_o.aligned    = leap;
  assign stat_o.d_ge_ylen  = (d_q >= d2d_pkg::DayW'(ylen));
  assign stat_o.month_last = (d_q < d2d_pkg::DayW'(mlen)) || (m_q == d2d_pkg::MonthDec);
  assign stat_o.out_free   = !valid_q || out_ready_i;

  always_comb begin
    d_d   = d_q;
    y_d   = y_q;
    m_d   = m_q;
    q_d   = q_q;
    inv_d = inv_q;
    if (cmd_i.load) begin
      d_d   = day_number_i - d2d_pkg::DayW'(1);
      y_d   = d2d_pkg::YearW'(EPOCH_YEAR);
      m_d   = '0;
      inv_d = (day_number_i == '0);
    end else if (cmd_i.year_step) begin
      d_d = d_q - d2d_pkg::DayW'(ylen);
      y_d = y_q + d2d_pkg::YearW'(1);
    end else if (cmd_i.div_step) begin
      q_d = prod[d2d_pkg::RecipShift +: d2d_pkg::QuotW];
    end else if (cmd_i.div_done) begin
      y_d = y_q + {q_q, 2'b00};
      d_d = d_q - blk_days;
    end else if (cmd_i.month_step) begin
      d_d = d_q - d2d_pkg::DayW'(mlen);
      m_d = m_q + d2d_pkg::MonW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    y_q   <= y_d;
    m_q   <= m_d;
    q_q   <= q_d;
    inv_q <= inv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      o_inv_q  <= inv_q;
      o_day_q  <= inv_q ? '0 : d_q[d2d_pkg::DomW-1:0] + d2d_pkg::DomW'(1);
      o_mon_q  <= inv_q ? '0 : m_q + d2d_pkg::MonW'(1);
      o_year_q <= inv_q ? '0 : y_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_day_o   = o_day_q;
  assign out_mon_o   = o_mon_q;
  assign out_year_o  = o_year_q;
  assign out_inv_o   = o_inv_q;

  // Once the year loops are done the remaining days fit in one year.
  `D2D_ASSERT_IMP(a_month_days, cmd_i.month_step, d_q < d2d_pkg::DayW'(d2d_pkg::LeapDays))
  // The month walk never runs past December.
  `D2D_ASSERT_ALW(a_month_range, !cmd_i.month_step || m_q < d2d_pkg::MonthDec)
  // A new result is only written once the previous one has left.
  `D2D_ASSERT_IMP(a_capture_free, cmd_i.capture, !valid_q || out_ready_i)

endmodule

`default_nettype wire
